// ===== hdl/gbr_pkg.sv =====
`default_nettype none

package gbr_pkg;

  // Bank geometry
  localparam int PIN_COUNT = 32;
  localparam int DATA_W    = 32;
  localparam int OFS_W     = 10;
  localparam int REQ_W     = 2;

  // Bits of implemented pins
  localparam logic [DATA_W-1:0] PIN_MASK =
    DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

  // Register window byte offsets
  localparam logic [OFS_W-1:0] OFS_REVISION  = OFS_W'(10'h000);
  localparam logic [OFS_W-1:0] OFS_IRQSTATUS = OFS_W'(10'h018);
  localparam logic [OFS_W-1:0] OFS_IRQENABLE = OFS_W'(10'h01C);
  localparam logic [OFS_W-1:0] OFS_OE        = OFS_W'(10'h034);
  localparam logic [OFS_W-1:0] OFS_DATAIN    = OFS_W'(10'h038);
  localparam logic [OFS_W-1:0] OFS_DATAOUT   = OFS_W'(10'h03C);
  localparam logic [OFS_W-1:0] OFS_RISE      = OFS_W'(10'h048);
  localparam logic [OFS_W-1:0] OFS_FALL      = OFS_W'(10'h04C);
  localparam logic [OFS_W-1:0] OFS_CLEAROUT  = OFS_W'(10'h090);
  localparam logic [OFS_W-1:0] OFS_SETOUT    = OFS_W'(10'h094);

  localparam logic [DATA_W-1:0] REVISION_VAL = DATA_W'(32'h25);

  // Request kinds as they arrive on the bus side
  typedef enum logic [REQ_W-1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Decoded register select
  typedef enum logic [3:0] {
    SEL_REVISION,
    SEL_IRQSTATUS,
    SEL_IRQENABLE,
    SEL_OE,
    SEL_DATAIN,
    SEL_DATAOUT,
    SEL_RISE,
    SEL_FALL,
    SEL_CLEAROUT,
    SEL_SETOUT,
    SEL_NONE
  } reg_sel_t;

  // Classified command handed from front to back
  typedef struct packed {
    req_t              kind;
    reg_sel_t          sel;
    logic [DATA_W-1:0] data;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pad_drive;
    logic [DATA_W-1:0] pad_enable_n;
    logic              irq_line;
    logic              access_error;
  } res_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic exec;
    logic res_full;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== hdl/gbr_front.sv =====
`default_nettype none

module gbr_front (
  input  wire logic [gbr_pkg::REQ_W-1:0]  req_type,
  input  wire logic [gbr_pkg::OFS_W-1:0]  reg_offset,
  input  wire logic [gbr_pkg::DATA_W-1:0] write_data,
  input  wire logic [gbr_pkg::DATA_W-1:0] pin_levels,
  output gbr_pkg::cmd_t                   cmd
);

  gbr_pkg::req_t     kind;
  gbr_pkg::reg_sel_t sel;

  // Offset decode
  always_comb begin
    case (reg_offset)
      gbr_pkg::OFS_REVISION:  sel = gbr_pkg::SEL_REVISION;
      gbr_pkg::OFS_IRQSTATUS: sel = gbr_pkg::SEL_IRQSTATUS;
      gbr_pkg::OFS_IRQENABLE: sel = gbr_pkg::SEL_IRQENABLE;
      gbr_pkg::OFS_OE:        sel = gbr_pkg::SEL_OE;
      gbr_pkg::OFS_DATAIN:    sel = gbr_pkg::SEL_DATAIN;
      gbr_pkg::OFS_DATAOUT:   sel = gbr_pkg::SEL_DATAOUT;
      gbr_pkg::OFS_RISE:      sel = gbr_pkg::SEL_RISE;
      gbr_pkg::OFS_FALL:      sel = gbr_pkg::SEL_FALL;
      gbr_pkg::OFS_CLEAROUT:  sel = gbr_pkg::SEL_CLEAROUT;
      gbr_pkg::OFS_SETOUT:    sel = gbr_pkg::SEL_SETOUT;
      default:                sel = gbr_pkg::SEL_NONE;
    endcase
  end

  // Classify and pick the payload word the back end needs
  always_comb begin
    kind = gbr_pkg::req_t'(req_type);
    cmd.kind = kind;
    cmd.sel  = sel;
    case (kind)
      gbr_pkg::REQ_TICK: cmd.data = pin_levels;
      default:           cmd.data = write_data;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gbr_cmd_queue.sv =====
`default_nettype none

module gbr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gbr_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output gbr_pkg::cmd_t      dout
);

  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  gbr_pkg::cmd_t e0_r;
  gbr_pkg::cmd_t e1_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = e0_r;

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Two-slot shift storage, head in slot 0
  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      e0_r <= e1_r;
    end else if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      e0_r <= din;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2 && pop))) begin
      e1_r <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gbr_back.sv =====
`default_nettype none

module gbr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire gbr_pkg::cmd_t cmd,
  output logic               cmd_pop,
  input  wire logic          res_pop,
  output logic               res_valid,
  output gbr_pkg::res_t      res,
  output gbr_pkg::back_stat_t stat
);

  localparam logic [gbr_pkg::DATA_W-1:0] MASK = gbr_pkg::PIN_MASK;

  // Bank registers
  logic [gbr_pkg::DATA_W-1:0] data_out_r,  data_out_nxt;
  logic [gbr_pkg::DATA_W-1:0] oe_n_r,      oe_n_nxt;
  logic [gbr_pkg::DATA_W-1:0] data_in_r,   data_in_nxt;
  logic [gbr_pkg::DATA_W-1:0] irq_en_r,    irq_en_nxt;
  logic [gbr_pkg::DATA_W-1:0] irq_stat_r,  irq_stat_nxt;
  logic [gbr_pkg::DATA_W-1:0] rise_r,      rise_nxt;
  logic [gbr_pkg::DATA_W-1:0] fall_r,      fall_nxt;

  logic [gbr_pkg::DATA_W-1:0] wd;
  logic [gbr_pkg::DATA_W-1:0] rd;
  logic [gbr_pkg::DATA_W-1:0] rises;
  logic [gbr_pkg::DATA_W-1:0] falls;
  logic                       exec;
  gbr_pkg::res_t              res_new;

  // Result queue
  logic [1:0]    rcnt_r;
  logic [1:0]    rcnt_nxt;
  logic          res_full;
  logic          rpop;
  gbr_pkg::res_t r0_r;
  gbr_pkg::res_t r1_r;

  assign res_full  = (rcnt_r == 2'd2);
  assign res_valid = (rcnt_r != 2'd0);
  assign res       = r0_r;
  assign rpop      = res_pop && res_valid;
  assign exec      = cmd_valid && !res_full;
  assign cmd_pop   = exec;
  assign stat.exec     = exec;
  assign stat.res_full = res_full;

  // Read mux on current state
  always_comb begin
    case (cmd.sel)
      gbr_pkg::SEL_REVISION:  rd = gbr_pkg::REVISION_VAL;
      gbr_pkg::SEL_IRQSTATUS: rd = irq_stat_r;
      gbr_pkg::SEL_IRQENABLE: rd = irq_en_r;
      gbr_pkg::SEL_OE:        rd = oe_n_r;
      gbr_pkg::SEL_DATAIN:    rd = data_in_r;
      gbr_pkg::SEL_DATAOUT:   rd = data_out_r;
      gbr_pkg::SEL_RISE:      rd = rise_r;
      gbr_pkg::SEL_FALL:      rd = fall_r;
      gbr_pkg::SEL_CLEAROUT:  rd = data_out_r;
      gbr_pkg::SEL_SETOUT:    rd = data_out_r;
      default:                rd = '0;
    endcase
  end

  // Next state for the command at the queue head
  always_comb begin
    wd    = cmd.data & MASK;
    rises = ~data_in_r & wd & rise_r;
    falls = data_in_r & ~wd & fall_r;
    data_out_nxt = data_out_r;
    oe_n_nxt     = oe_n_r;
    data_in_nxt  = data_in_r;
    irq_en_nxt   = irq_en_r;
    irq_stat_nxt = irq_stat_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    res_new.read_data    = '0;
    res_new.access_error = 1'b0;
    case (cmd.kind)
      gbr_pkg::REQ_READ: begin
        res_new.read_data    = rd;
        res_new.access_error = (cmd.sel == gbr_pkg::SEL_NONE);
      end
      gbr_pkg::REQ_WRITE: begin
        res_new.access_error = (cmd.sel == gbr_pkg::SEL_NONE);
        case (cmd.sel)
          gbr_pkg::SEL_IRQSTATUS: irq_stat_nxt = irq_stat_r & ~wd;
          gbr_pkg::SEL_IRQENABLE: irq_en_nxt   = wd;
          gbr_pkg::SEL_OE:        oe_n_nxt     = wd;
          gbr_pkg::SEL_DATAOUT:   data_out_nxt = wd;
          gbr_pkg::SEL_RISE:      rise_nxt     = wd;
          gbr_pkg::SEL_FALL:      fall_nxt     = wd;
          gbr_pkg::SEL_CLEAROUT:  data_out_nxt = data_out_r & ~wd;
          gbr_pkg::SEL_SETOUT:    data_out_nxt = data_out_r | wd;
          default:                data_out_nxt = data_out_r;
        endcase
      end
      gbr_pkg::REQ_TICK: begin
        irq_stat_nxt = (irq_stat_r | rises | falls) & MASK;
        data_in_nxt  = wd;
      end
      default: begin
        res_new.read_data = '0;
      end
    endcase
    res_new.pad_drive    = data_out_nxt;
    res_new.pad_enable_n = oe_n_nxt;
    res_new.irq_line     = |(irq_stat_nxt & irq_en_nxt);
  end

  // Bank register update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_out_r <= '0;
      oe_n_r     <= MASK;
      data_in_r  <= '0;
      irq_en_r   <= '0;
      irq_stat_r <= '0;
      rise_r     <= '0;
      fall_r     <= '0;
    end else if (exec) begin
      data_out_r <= data_out_nxt;
      oe_n_r     <= oe_n_nxt;
      data_in_r  <= data_in_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_stat_r <= irq_stat_nxt;
      rise_r     <= rise_nxt;
      fall_r     <= fall_nxt;
    end
  end

  // Result queue occupancy
  always_comb begin
    rcnt_nxt = rcnt_r + {1'b0, exec} - {1'b0, rpop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= 2'd0;
    end else begin
      rcnt_r <= rcnt_nxt;
    end
  end

  // Result storage, head in slot 0
  always_ff @(posedge clk) begin
    if (rpop && rcnt_r == 2'd2) begin
      r0_r <= r1_r;
    end else if (exec && (rcnt_r == 2'd0 || (rcnt_r == 2'd1 && rpop))) begin
      r0_r <= res_new;
    end
    if (exec && ((rcnt_r == 2'd1 && !rpop) || (rcnt_r == 2'd2 && rpop))) begin
      r1_r <= res_new;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpio_bank_registers.sv =====
`default_nettype none

// 32-pin GPIO bank behind a register window.
// Input channel: bus reads, bus writes and pin-sample ticks. A transaction
// is taken at a clock edge with in_push high and in_full low.
// Result channel: one result per transaction, in order. The oldest result
// sits on the out_ ports while out_empty is low and leaves at an edge with
// out_pop high.
// A result reaches the out_ ports through both queues: the taking edge writes
// the command queue, and a later edge, once the result queue has room, executes
// the command into the result queue, from which the result can then be popped.
// Throughput: one transaction per cycle while the result queue has room; the
// execute stage does a read-modify-write of the bank flops for each command.
// Both the command queue and the result queue hold two entries. When the
// receiver stalls, results collect in the result queue, then the command
// queue fills and in_full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues, clears all bank
// registers and sets output enable to all ones (no pin driven).
module gpio_bank_registers (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [gbr_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [gbr_pkg::OFS_W-1:0]   in_reg_offset,
  input  wire logic [gbr_pkg::DATA_W-1:0]  in_write_data,
  input  wire logic [gbr_pkg::DATA_W-1:0]  in_pin_levels,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [gbr_pkg::DATA_W-1:0]       out_read_data,
  output logic [gbr_pkg::DATA_W-1:0]       out_pad_drive,
  output logic [gbr_pkg::DATA_W-1:0]       out_pad_enable_n,
  output logic                             out_irq_line,
  output logic                             out_access_error
);

  gbr_pkg::cmd_t       cmd_in;
  gbr_pkg::cmd_t       cmd_head;
  gbr_pkg::res_t       res;
  gbr_pkg::back_stat_t stat;
  logic                cq_full;
  logic                cq_valid;
  logic                cq_pop;
  logic                res_valid;
  logic                in_take;

  assign in_full = cq_full;
  assign in_take = in_push && !cq_full;

  // Front: classify the incoming transaction
  gbr_front u_front (
    .req_type   (in_req_type),
    .reg_offset (in_reg_offset),
    .write_data (in_write_data),
    .pin_levels (in_pin_levels),
    .cmd        (cmd_in)
  );

  // Decoupling queue
  gbr_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_take),
    .din   (cmd_in),
    .full  (cq_full),
    .pop   (cq_pop),
    .valid (cq_valid),
    .dout  (cmd_head)
  );

  // Back: execute against the bank registers
  gbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cq_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  assign out_empty        = !res_valid;
  assign out_read_data    = res.read_data;
  assign out_pad_drive    = res.pad_drive;
  assign out_pad_enable_n = res.pad_enable_n;
  assign out_irq_line     = res.irq_line;
  assign out_access_error = res.access_error;

  // Checks
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> cq_valid)
    else $error("accepted transaction missing from command queue");

  a_exec_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    stat.exec |-> cq_valid && !stat.res_full)
    else $error("execute without command or result space");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_access_error |-> out_read_data == '0)
    else $error("error result carries read data");

endmodule

`default_nettype wire
